>>> hw/rtl/rsst_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and types of the range-sum segment tree.
// No dependencies; the top level and the tree walker refer to it by scoped names.
package rsst_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;

    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] REQ_SET = 2'd0;
    localparam logic [KIND_W-1:0] REQ_ADD = 2'd1;
    localparam logic [KIND_W-1:0] REQ_SUM = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef logic [VAL_W-1:0] t_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ctrl_stat;

endpackage

>>> hw/rtl/range_sum_segment_tree.sv
`timescale 1ns / 1ps
// Point-update, range-sum segment tree of 64-bit wrapping sums in one synchronous RAM.
// Depends on rsst_pkg, rsst_ram and rsst_ctrl.
//
// After reset the block clears all 2 * 2^ceil(log2(MAX_ELEMENTS)) entries of the tree
// memory (2048 at the default) and accepts no request meanwhile; count writes are taken
// at any time the block is idle. One request is in work at a time. A set first walks to
// the leaf for its old value and then updates the path as an add does; each tree level
// is read through the single read port, with the write-back of the previous level
// overlapped. A range sum reads at most one node per cycle along the split path and then
// the left and right boundary paths, and none when the range is empty. A finished sum
// waits in the output register while the next request is accepted.
module range_sum_segment_tree #(
    parameter int MAX_ELEMENTS = rsst_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rsst_pkg::COUNT_W-1:0]       i_cfg_wdata,   // element_count
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // element_index [9:0], value [73:10], range_left [83:74], range_right [93:84], zero pad
    input  logic [95:0]                        s_axis_tdata,
    input  logic [rsst_pkg::KIND_W-1:0]        s_axis_tuser,  // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rsst_pkg::VAL_W-1:0]         m_axis_tdata   // range_total
);

    localparam int NODE_W = $clog2(MAX_ELEMENTS) + 1;
    localparam int DEPTH  = 2 ** NODE_W;
    localparam int CW     = rsst_pkg::COUNT_W;

    localparam logic [CW-1:0] COUNT_INIT =
        (MAX_ELEMENTS < 1024) ? CW'(MAX_ELEMENTS) : rsst_pkg::COUNT_RESET;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         w_count_wr;
    logic                  r_clr_busy;
    logic [NODE_W-1:0]     r_clr_addr;
    logic                  r_out_valid;
    rsst_pkg::t_word       r_out_data;

    logic                  w_start;
    logic                  w_out_free;
    rsst_pkg::t_ctrl_stat  w_stat;
    rsst_pkg::t_word       w_total;
    logic                  w_ctrl_rd_en;
    logic [NODE_W-1:0]     w_ctrl_rd_addr;
    logic                  w_ctrl_wr_en;
    logic [NODE_W-1:0]     w_ctrl_wr_addr;
    rsst_pkg::t_word       w_ctrl_wr_data;
    rsst_pkg::t_word       w_rd_data;
    logic                  w_mem_wr_en;
    logic [NODE_W-1:0]     w_mem_wr_addr;
    rsst_pkg::t_word       w_mem_wr_data;

    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            w_count_wr = CW'(1);
        end else if (32'(i_cfg_wdata) > MAX_ELEMENTS) begin
            w_count_wr = CW'(MAX_ELEMENTS);
        end else begin
            w_count_wr = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_INIT;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= w_count_wr;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + NODE_W'(1);
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_stat.done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out_data <= w_total;
        end
    end

    assign s_axis_tready = !r_clr_busy && !w_stat.busy;
    assign w_start       = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_mem_wr_en   = r_clr_busy || w_ctrl_wr_en;
    assign w_mem_wr_addr = r_clr_busy ? r_clr_addr : w_ctrl_wr_addr;
    assign w_mem_wr_data = r_clr_busy ? '0 : w_ctrl_wr_data;

    rsst_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (s_axis_tuser),
        .i_index    (s_axis_tdata[9:0]),
        .i_value    (s_axis_tdata[73:10]),
        .i_left     (s_axis_tdata[83:74]),
        .i_right    (s_axis_tdata[93:84]),
        .i_count    (r_count),
        .i_out_free (w_out_free),
        .o_rd_en    (w_ctrl_rd_en),
        .o_rd_addr  (w_ctrl_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_wr_en    (w_ctrl_wr_en),
        .o_wr_addr  (w_ctrl_wr_addr),
        .o_wr_data  (w_ctrl_wr_data),
        .o_total    (w_total),
        .o_stat     (w_stat)
    );

    rsst_ram #(
        .WIDTH (rsst_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_tree_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_en   (w_ctrl_rd_en),
        .i_rd_addr (w_ctrl_rd_addr),
        .o_rd_data (w_rd_data)
    );

    a_no_walk_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_ctrl_wr_en)
        else $error("tree walker wrote during the clearing pass");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("request taken before the tree memory was cleared");

    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (!r_out_valid || m_axis_tready))
        else $error("range sum finished while the output register was still held");

    a_no_same_entry_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl_wr_en && w_ctrl_rd_en) |-> (w_ctrl_wr_addr != w_ctrl_rd_addr))
        else $error("read and write-back hit the same tree node in one cycle");

endmodule

>>> hw/rtl/rsst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rsst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> hw/rtl/rsst_ctrl.sv
`timescale 1ns / 1ps
// Tree walker: point updates as read-modify-write down one path, range sums along two paths.
// Depends on rsst_pkg; drives the tree memory held by the top level.
module rsst_ctrl #(
    parameter int MAX_ELEMENTS = rsst_pkg::DEF_MAX_ELEMENTS,
    localparam int NODE_W = $clog2(MAX_ELEMENTS) + 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rsst_pkg::KIND_W-1:0]         i_kind,
    input  logic [rsst_pkg::IDX_W-1:0]          i_index,
    input  rsst_pkg::t_word                     i_value,
    input  logic [rsst_pkg::IDX_W-1:0]          i_left,
    input  logic [rsst_pkg::IDX_W-1:0]          i_right,
    input  logic [rsst_pkg::COUNT_W-1:0]        i_count,
    input  logic                                i_out_free,
    output logic                                o_rd_en,
    output logic [NODE_W-1:0]                   o_rd_addr,
    input  rsst_pkg::t_word                     i_rd_data,
    output logic                                o_wr_en,
    output logic [NODE_W-1:0]                   o_wr_addr,
    output rsst_pkg::t_word                     o_wr_data,
    output rsst_pkg::t_word                     o_total,
    output rsst_pkg::t_ctrl_stat                o_stat
);

    localparam int PW = rsst_pkg::POS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_OLD   = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_LPATH = 4'd6;
    localparam logic [3:0] S_RPATH = 4'd7;
    localparam logic [3:0] S_QWAIT = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);

    logic [3:0]        r_state, n_state;
    logic [NODE_W-1:0] r_node, n_node;
    logic [PW-1:0]     r_lo, n_lo;
    logic [PW-1:0]     r_hi, n_hi;
    logic [NODE_W-1:0] r_rnode, n_rnode;
    logic [PW-1:0]     r_rlo, n_rlo;
    logic [PW-1:0]     r_rhi, n_rhi;
    logic [PW-1:0]     r_idx, n_idx;
    logic [PW-1:0]     r_left, n_left;
    logic [PW-1:0]     r_right, n_right;
    rsst_pkg::t_word   r_diff, n_diff;
    rsst_pkg::t_word   r_acc, n_acc;
    logic              r_acc_pend, n_acc_pend;
    logic              r_wr_pend, n_wr_pend;
    logic [NODE_W-1:0] r_wr_addr, n_wr_addr;

    logic [PW:0]       w_sum;
    logic [PW-1:0]     w_mid;
    logic [PW-1:0]     w_mid_p1;
    logic [NODE_W-1:0] w_lchild;
    logic [NODE_W-1:0] w_rchild;
    logic              w_leaf;
    logic [PW-1:0]     w_cnt_m1;
    logic [PW-1:0]     w_in_idx;
    logic [PW-1:0]     w_in_left;
    logic [PW-1:0]     w_in_right;
    logic [PW-1:0]     w_right_c;
    logic              w_done;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[PW:1];
    assign w_mid_p1   = w_mid + PW'(1);
    assign w_lchild   = {r_node[NODE_W-2:0], 1'b0};
    assign w_rchild   = {r_node[NODE_W-2:0], 1'b1};
    assign w_leaf     = (r_lo == r_hi);
    assign w_cnt_m1   = PW'(i_count - rsst_pkg::COUNT_W'(1));
    assign w_in_idx   = PW'(i_index);
    assign w_in_left  = PW'(i_left);
    assign w_in_right = PW'(i_right);
    assign w_right_c  = (w_in_right > w_cnt_m1) ? w_cnt_m1 : w_in_right;

    always_comb begin
        n_state    = r_state;
        n_node     = r_node;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_rnode    = r_rnode;
        n_rlo      = r_rlo;
        n_rhi      = r_rhi;
        n_idx      = r_idx;
        n_left     = r_left;
        n_right    = r_right;
        n_diff     = r_diff;
        n_acc      = r_acc_pend ? (r_acc + i_rd_data) : r_acc;
        n_acc_pend = 1'b0;
        n_wr_pend  = 1'b0;
        n_wr_addr  = r_wr_addr;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_node;
        w_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_node  = ROOT;
                    n_lo    = '0;
                    n_hi    = w_cnt_m1;
                    n_idx   = w_in_idx;
                    n_left  = w_in_left;
                    n_right = w_right_c;
                    n_diff  = i_value;
                    n_acc   = '0;
                    unique case (i_kind)
                        rsst_pkg::REQ_SET: begin
                            if (w_in_idx <= w_cnt_m1) begin
                                n_state = S_FIND;
                            end
                        end
                        rsst_pkg::REQ_ADD: begin
                            if (w_in_idx <= w_cnt_m1) begin
                                n_state = S_UPD;
                            end
                        end
                        rsst_pkg::REQ_SUM: begin
                            if (w_in_left <= w_right_c) begin
                                n_state = S_SPLIT;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (w_leaf) begin
                    o_rd_en = 1'b1;
                    n_state = S_OLD;
                end else if (r_idx <= w_mid) begin
                    n_node = w_lchild;
                    n_hi   = w_mid;
                end else begin
                    n_node = w_rchild;
                    n_lo   = w_mid_p1;
                end
            end
            S_OLD: begin
                n_diff  = r_diff - i_rd_data;
                n_node  = ROOT;
                n_lo    = '0;
                n_hi    = w_cnt_m1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_rd_en   = 1'b1;
                n_wr_pend = 1'b1;
                n_wr_addr = r_node;
                if (w_leaf) begin
                    n_state = S_DRAIN;
                end else if (r_idx <= w_mid) begin
                    n_node = w_lchild;
                    n_hi   = w_mid;
                end else begin
                    n_node = w_rchild;
                    n_lo   = w_mid_p1;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_SPLIT: begin
                if (r_left <= r_lo && r_hi <= r_right) begin
                    o_rd_en    = 1'b1;
                    n_acc_pend = 1'b1;
                    n_state    = S_QWAIT;
                end else if (r_right <= w_mid) begin
                    n_node = w_lchild;
                    n_hi   = w_mid;
                end else if (r_left > w_mid) begin
                    n_node = w_rchild;
                    n_lo   = w_mid_p1;
                end else begin
                    n_node  = w_lchild;
                    n_hi    = w_mid;
                    n_rnode = w_rchild;
                    n_rlo   = w_mid_p1;
                    n_rhi   = r_hi;
                    n_state = S_LPATH;
                end
            end
            S_LPATH: begin
                if (r_left <= r_lo) begin
                    o_rd_en    = 1'b1;
                    n_acc_pend = 1'b1;
                    n_node     = r_rnode;
                    n_lo       = r_rlo;
                    n_hi       = r_rhi;
                    n_state    = S_RPATH;
                end else if (r_left <= w_mid) begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = w_rchild;
                    n_acc_pend = 1'b1;
                    n_node     = w_lchild;
                    n_hi       = w_mid;
                end else begin
                    n_node = w_rchild;
                    n_lo   = w_mid_p1;
                end
            end
            S_RPATH: begin
                if (r_hi <= r_right) begin
                    o_rd_en    = 1'b1;
                    n_acc_pend = 1'b1;
                    n_state    = S_QWAIT;
                end else if (r_right > w_mid) begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = w_lchild;
                    n_acc_pend = 1'b1;
                    n_node     = w_rchild;
                    n_lo       = w_mid_p1;
                end else begin
                    n_node = w_lchild;
                    n_hi   = w_mid;
                end
            end
            S_QWAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc_pend <= 1'b0;
            r_wr_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_acc_pend <= n_acc_pend;
            r_wr_pend  <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_rnode   <= n_rnode;
        r_rlo     <= n_rlo;
        r_rhi     <= n_rhi;
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_right   <= n_right;
        r_diff    <= n_diff;
        r_acc     <= n_acc;
        r_wr_addr <= n_wr_addr;
    end

    assign o_wr_en     = r_wr_pend;
    assign o_wr_addr   = r_wr_addr;
    assign o_wr_data   = i_rd_data + r_diff;
    assign o_total     = r_acc;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = w_done;

endmodule
